// ===== rtl/tphc_pkg.sv =====
package tphc_pkg;

	localparam int unsigned HEADER_BYTES     = 24;
	localparam int unsigned HDR_WORD_BYTES   = 2;
	localparam int unsigned MAX_PACKET_BYTES = 524288;

	// packet offset counter covers 0..MAX_PACKET_BYTES
	localparam int unsigned PO_W  = $clog2(MAX_PACKET_BYTES + 1);
	localparam int unsigned HDR_AW = $clog2(HEADER_BYTES);

	localparam logic [15:0] SYNC_RESET = 16'hEB25;

	localparam logic [1:0] PH_HUNT   = 2'd0;
	localparam logic [1:0] PH_EXPECT = 2'd1;
	localparam logic [1:0] PH_HEADER = 2'd2;
	localparam logic [1:0] PH_BODY   = 2'd3;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_HDR_EXCEEDS = 3'd1;
	localparam logic [2:0] ST_SYNC_BAD    = 3'd2;
	localparam logic [2:0] ST_HDR_SUM_BAD = 3'd3;
	localparam logic [2:0] ST_BODY_EXCEED = 3'd4;
	localparam logic [2:0] ST_DATA_SUM_BAD = 3'd5;

	localparam logic [1:0] CK_NONE = 2'd0;
	localparam logic [1:0] CK_8    = 2'd1;
	localparam logic [1:0] CK_16   = 2'd2;
	localparam logic [1:0] CK_32   = 2'd3;

	typedef struct packed {
		logic [31:0] packet_start;
		logic [47:0] relative_time;
		logic        timestamp_source;
		logic [1:0]  time_format;
		logic [7:0]  data_kind;
		logic [31:0] body_length;
		logic [31:0] packet_length;
		logic [15:0] channel_number;
	} result_t;

endpackage

// ===== rtl/telemetry_packet_header_checker_core.sv =====
// Channel  Group            Transaction
// -------  ---------------  ------------------------------------------------------
// in       s_tvalid/tready  tdata[7:0] data_byte, tlast end_of_buffer
// cfg      cfg_valid/ready  cfg_data[15:0] sync_word (always ready)
// out      m_tvalid/tready  tuser[2:0] status, tdata = decoded header + packet_start
//
// One byte per clock while s_tready is high; each byte is checked in the cycle it is accepted.
// A result lands in the output register on the edge that accepts the byte ending
// the packet or raising the error, so it shows in the cycle after that edge.
// s_tready drops only while the output register holds a result not yet taken.
// Reset returns to sync hunt with offsets zeroed; the header store needs no clear.
module telemetry_packet_header_checker_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,   // end_of_buffer
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data,  // [15:0] sync_word
	output logic         m_tvalid,
	input  logic         m_tready,
	// [15:0] channel_number, [47:16] packet_length, [79:48] body_length,
	// [87:80] data_kind, [89:88] time_format, [90] timestamp_source,
	// [138:91] relative_time, [170:139] packet_start, [175:171] zero
	output logic [175:0] m_tdata,
	output logic [2:0]   m_tuser    // [2:0] status
);

	localparam int unsigned PW = tphc_pkg::PO_W;

	logic [1:0]    phase_q;
	logic [31:0]   so_q;
	logic [PW-1:0] po_q;
	logic [7:0]    hdr_q [tphc_pkg::HEADER_BYTES];
	logic [7:0]    prev_q;
	logic [15:0]   hsum_q;
	logic [31:0]   bsum_q;
	logic [31:0]   uasm_q;
	logic [31:0]   pend_q;
	logic [31:0]   start_q;
	logic [15:0]   sync_q;
	logic [PW-1:0] sum_end_q;
	logic [PW-1:0] tail_q;
	logic [PW-1:0] last_q;

	logic                 m_valid_q;
	logic [2:0]           m_status_q;
	tphc_pkg::result_t    m_res_q;

	logic          acc;
	logic [7:0]    b;
	logic          eob;
	logic [1:0]    phase_d;
	logic [PW-1:0] po_d;
	logic [15:0]   hsum_d;
	logic [31:0]   bsum_d;
	logic [31:0]   uasm_d;
	logic [31:0]   pend_d;
	logic [31:0]   start_d;
	logic          hdr_we;
	logic [tphc_pkg::HDR_AW-1:0] hdr_wa;
	logic          thr_ld;
	logic          emit;
	logic [2:0]    st;
	logic          dec;

	logic [31:0]   plen;
	logic [1:0]    ck_code;
	logic [2:0]    ub;
	logic [31:0]   ck_mask;
	logic [PW-1:0] plen_n;
	logic [PW-1:0] span;
	logic [15:0]   word_in;
	logic [1:0]    k;
	logic [31:0]   asm_next;
	logic [1:0]    tail_idx;
	tphc_pkg::result_t res_d;

	assign acc       = s_tvalid && s_tready;
	assign s_tready  = !m_valid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign b         = s_tdata;
	assign eob       = s_tlast;
	assign word_in   = {b, prev_q};

	assign plen    = {hdr_q[7], hdr_q[6], hdr_q[5], hdr_q[4]};
	assign ck_code = hdr_q[14][1:0];
	assign plen_n  = plen[PW-1:0];

	always_comb begin
		case (ck_code)
			tphc_pkg::CK_8: begin
				ub      = 3'd1;
				ck_mask = 32'h0000_00FF;
			end
			tphc_pkg::CK_16: begin
				ub      = 3'd2;
				ck_mask = 32'h0000_FFFF;
			end
			tphc_pkg::CK_32: begin
				ub      = 3'd4;
				ck_mask = 32'hFFFF_FFFF;
			end
			default: begin
				ub      = 3'd0;
				ck_mask = 32'h0000_0000;
			end
		endcase
	end

	// summed region ends on a unit boundary before the trailing checksum unit
	assign span = (plen_n - PW'(tphc_pkg::HEADER_BYTES) - PW'(ub))
		& ~(PW'(ub) - PW'(1));

	assign k        = po_q[1:0] & (ub[1:0] - 2'd1);
	assign asm_next = uasm_q | (32'(b) << {k, 3'b000});
	assign tail_idx = 2'(po_q - tail_q);

	always_comb begin
		phase_d = phase_q;
		po_d    = po_q;
		hsum_d  = hsum_q;
		bsum_d  = bsum_q;
		uasm_d  = uasm_q;
		pend_d  = pend_q;
		start_d = start_q;
		hdr_we  = 1'b0;
		hdr_wa  = po_q[tphc_pkg::HDR_AW-1:0];
		thr_ld  = 1'b0;
		emit    = 1'b0;
		st      = tphc_pkg::ST_OK;
		dec     = 1'b0;
		case (phase_q)
			tphc_pkg::PH_HUNT: begin
				hdr_we = 1'b1;
				if (po_q == PW'(1) && word_in == sync_q) begin
					start_d = so_q - 32'd1;
					hsum_d  = word_in;
					hdr_wa  = tphc_pkg::HDR_AW'(1);
					po_d    = PW'(2);
					phase_d = tphc_pkg::PH_HEADER;
					if (eob) begin
						emit    = 1'b1;
						st      = tphc_pkg::ST_HDR_EXCEEDS;
						phase_d = tphc_pkg::PH_HUNT;
						po_d    = '0;
					end
				end else begin
					hdr_wa = '0;
					po_d   = eob ? PW'(0) : PW'(1);
				end
			end
			tphc_pkg::PH_EXPECT: begin
				hdr_we = 1'b1;
				if (po_q == '0) begin
					start_d = so_q;
					hdr_wa  = '0;
					po_d    = PW'(1);
					if (eob) begin
						emit    = 1'b1;
						st      = tphc_pkg::ST_HDR_EXCEEDS;
						phase_d = tphc_pkg::PH_HUNT;
						po_d    = '0;
					end
				end else begin
					hsum_d = word_in;
					hdr_wa = tphc_pkg::HDR_AW'(1);
					if (eob || word_in != sync_q) begin
						emit    = 1'b1;
						st      = eob ? tphc_pkg::ST_HDR_EXCEEDS : tphc_pkg::ST_SYNC_BAD;
						phase_d = tphc_pkg::PH_HUNT;
						po_d    = '0;
					end else begin
						po_d    = PW'(2);
						phase_d = tphc_pkg::PH_HEADER;
					end
				end
			end
			tphc_pkg::PH_HEADER: begin
				hdr_we = 1'b1;
				if (po_q[0] && po_q < PW'(tphc_pkg::HEADER_BYTES - tphc_pkg::HDR_WORD_BYTES))
					hsum_d = hsum_q + word_in;
				if (po_q < PW'(tphc_pkg::HEADER_BYTES - 1)) begin
					if (eob) begin
						emit    = 1'b1;
						st      = tphc_pkg::ST_HDR_EXCEEDS;
						phase_d = tphc_pkg::PH_HUNT;
						po_d    = '0;
					end else begin
						po_d = po_q + PW'(1);
					end
				end else begin
					dec     = 1'b1;
					phase_d = tphc_pkg::PH_HUNT;
					po_d    = '0;
					if ({b, hdr_q[22]} != hsum_q) begin
						emit = 1'b1;
						st   = tphc_pkg::ST_HDR_SUM_BAD;
					end else if (plen > 32'(tphc_pkg::MAX_PACKET_BYTES)) begin
						emit = 1'b1;
						st   = tphc_pkg::ST_BODY_EXCEED;
					end else if (plen < 32'(tphc_pkg::HEADER_BYTES) + 32'(ub)) begin
						emit = 1'b1;
						st   = tphc_pkg::ST_DATA_SUM_BAD;
					end else if (plen == 32'(tphc_pkg::HEADER_BYTES)) begin
						emit    = 1'b1;
						phase_d = tphc_pkg::PH_EXPECT;
					end else if (eob) begin
						emit = 1'b1;
						st   = tphc_pkg::ST_BODY_EXCEED;
					end else begin
						phase_d = tphc_pkg::PH_BODY;
						po_d    = PW'(tphc_pkg::HEADER_BYTES);
						bsum_d  = '0;
						uasm_d  = '0;
						pend_d  = '0;
						thr_ld  = 1'b1;
					end
				end
			end
			default: begin
				if (ub != 3'd0) begin
					if (po_q < sum_end_q) begin
						uasm_d = asm_next;
						if (k == ub[1:0] - 2'd1) begin
							bsum_d = (bsum_q + asm_next) & ck_mask;
							uasm_d = '0;
						end
					end
					if (po_q >= tail_q)
						pend_d = pend_q | (32'(b) << {tail_idx, 3'b000});
				end
				dec = 1'b1;
				if (po_q >= last_q) begin
					// summing never touches the last byte, so bsum_q is final here
					emit    = 1'b1;
					st      = (ub != 3'd0 && pend_d != bsum_q) ? tphc_pkg::ST_DATA_SUM_BAD
						: tphc_pkg::ST_OK;
					phase_d = tphc_pkg::PH_EXPECT;
					po_d    = '0;
				end else if (eob) begin
					emit    = 1'b1;
					st      = tphc_pkg::ST_BODY_EXCEED;
					phase_d = tphc_pkg::PH_HUNT;
					po_d    = '0;
				end else begin
					po_d = po_q + PW'(1);
				end
			end
		endcase
	end

	always_comb begin
		res_d = '0;
		if (dec) begin
			res_d.channel_number   = {hdr_q[3], hdr_q[2]};
			res_d.packet_length    = plen;
			res_d.body_length      = {hdr_q[11], hdr_q[10], hdr_q[9], hdr_q[8]};
			res_d.data_kind        = hdr_q[15];
			res_d.time_format      = hdr_q[14][3:2];
			res_d.timestamp_source = hdr_q[14][6];
			res_d.relative_time    = {hdr_q[21], hdr_q[20], hdr_q[19], hdr_q[18],
				hdr_q[17], hdr_q[16]};
		end
		res_d.packet_start = start_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tphc_pkg::PH_HUNT;
			so_q    <= '0;
			po_q    <= '0;
			hsum_q  <= '0;
			bsum_q  <= '0;
			uasm_q  <= '0;
			pend_q  <= '0;
			start_q <= '0;
		end else if (acc) begin
			phase_q <= phase_d;
			so_q    <= so_q + 32'd1;
			po_q    <= po_d;
			hsum_q  <= hsum_d;
			bsum_q  <= bsum_d;
			uasm_q  <= uasm_d;
			pend_q  <= pend_d;
			start_q <= start_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sync_q <= tphc_pkg::SYNC_RESET;
		else if (cfg_valid && cfg_ready)
			sync_q <= cfg_data;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			prev_q <= b;
			if (hdr_we)
				hdr_q[hdr_wa] <= b;
		end
		if (acc && thr_ld) begin
			sum_end_q <= PW'(tphc_pkg::HEADER_BYTES) + span;
			tail_q    <= plen_n - PW'(ub);
			last_q    <= plen_n - PW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (acc && emit)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (acc && emit) begin
			m_status_q <= st;
			m_res_q    <= res_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {5'b00000, m_res_q};

	a_hunt_po: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == tphc_pkg::PH_HUNT |-> po_q <= PW'(1))
		else $error("hunt offset out of range");

	a_header_po: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == tphc_pkg::PH_HEADER |->
			(po_q >= PW'(2) && po_q < PW'(tphc_pkg::HEADER_BYTES)))
		else $error("header offset out of range");

	a_body_po: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == tphc_pkg::PH_BODY |->
			(po_q >= PW'(tphc_pkg::HEADER_BYTES) && po_q <= last_q))
		else $error("body offset out of range");

	a_ok_expect: assert property (@(posedge clk) disable iff (!arst_n)
		acc && emit && st == tphc_pkg::ST_OK |=> phase_q == tphc_pkg::PH_EXPECT)
		else $error("good packet did not lead to sync expect");

	a_no_decode: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && (m_status_q == tphc_pkg::ST_HDR_EXCEEDS
			|| m_status_q == tphc_pkg::ST_SYNC_BAD)
		|-> (m_res_q.packet_length == '0 && m_res_q.relative_time == '0))
		else $error("header fields reported without a full header");

endmodule
